FILE: src/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg: shared definitions for the set-associative tag lookup
// Geometry constants, set row layout and controller states.
// ----------------------------------------------------------------------------
package sacl_pkg;

	// SETS is a power of two: the set index is the low address bits
	localparam int SETS      = 1024;
	localparam int WAYS      = 4;
	localparam int ADDR_BITS = 32;

	localparam int IN_ADDR_W = 32;
	localparam int ADDR_USE  = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
	localparam int SET_BITS  = $clog2(SETS);
	localparam int TAG_W     = ADDR_USE - SET_BITS;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int OUT_WAY_W = 2;
	localparam int CNT_W     = 32;

	// one RAM row holds the whole set
	typedef struct packed {
		logic [WAYS-1:0]             valid;
		logic [WAY_W-1:0]            ptr;
		logic [WAYS-1:0][TAG_W-1:0]  tag;
	} set_row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

endpackage

FILE: src/sacl_lookup_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_lookup_if: lookup request channel
// Valid/ready channel carrying one read address per request.
// ----------------------------------------------------------------------------
interface sacl_lookup_if;
	logic                           valid;
	logic                           ready;
	logic [sacl_pkg::IN_ADDR_W-1:0] addr;

	modport source (output valid, output addr, input ready);
	modport sink   (input valid, input addr, output ready);
endinterface

FILE: src/sacl_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_result_if: lookup result channel
// Valid/ready channel carrying hit, way and the running counters.
// ----------------------------------------------------------------------------
interface sacl_result_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [sacl_pkg::OUT_WAY_W-1:0] way;
	logic [sacl_pkg::CNT_W-1:0]     request_count;
	logic [sacl_pkg::CNT_W-1:0]     miss_count;

	modport source (output valid, output hit, output way, output request_count,
		output miss_count, input ready);
	modport sink   (input valid, input hit, input way, input request_count,
		input miss_count, output ready);
endinterface

FILE: src/sacl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/set_assoc_cache_tag_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_core: set-associative tag lookup, round-robin fill
// Looks up one address per request, fills misses, counts requests and misses.
// ----------------------------------------------------------------------------
//  port   | dir | channel contents
//  -------+-----+-----------------------------------------------
//  req    | in  | valid/ready, addr
//  rsp    | out | valid/ready, hit, way, request_count, miss_count
//
//  A request first reads the set row from the tag RAM, then compares all
//  ways and, on a miss, writes the updated row back.
//  After reset a clearing pass writes every set row (SETS = 1024);
//  req.ready stays low during it.
//  A result waits in the output register; the next request is accepted
//  meanwhile, and its write-back stalls only while that result is untaken.
module set_assoc_cache_tag_lookup_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sacl_lookup_if.sink          req,
	sacl_result_if.source        rsp
);

	localparam int ROW_W = $bits(sacl_pkg::set_row_t);

	sacl_pkg::ctrl_state_t state_q, state_d;

	logic [sacl_pkg::SET_BITS-1:0]  clr_q;
	logic [sacl_pkg::SET_BITS-1:0]  set_s1;
	logic [sacl_pkg::TAG_W-1:0]     tag_s1;
	logic                           out_valid_q;
	logic                           out_hit_q;
	logic [sacl_pkg::OUT_WAY_W-1:0] out_way_q;
	logic [sacl_pkg::CNT_W-1:0]     req_cnt_q;
	logic [sacl_pkg::CNT_W-1:0]     miss_cnt_q;

	logic                           ram_we;
	logic [sacl_pkg::SET_BITS-1:0]  ram_waddr;
	logic [ROW_W-1:0]               ram_wdata;
	logic                           ram_re;
	logic [ROW_W-1:0]               ram_rdata;

	sacl_pkg::set_row_t             rd_row, wr_row;
	logic [sacl_pkg::WAYS-1:0]      match;
	logic                           found, have_empty, commit;
	logic [sacl_pkg::WAY_W-1:0]     hit_way, empty_way, chosen, ptr_next;

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (sacl_pkg::SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (req.addr[sacl_pkg::SET_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// way compare and victim choice
	always_comb begin
		rd_row     = sacl_pkg::set_row_t'(ram_rdata);
		hit_way    = '0;
		empty_way  = '0;
		have_empty = 1'b0;
		// scan downward so the lowest way wins
		for (int w = sacl_pkg::WAYS - 1; w >= 0; w--) begin
			match[w] = rd_row.valid[w] && (rd_row.tag[w] == tag_s1);
			if (match[w]) begin
				hit_way = sacl_pkg::WAY_W'(w);
			end
			if (!rd_row.valid[w]) begin
				empty_way  = sacl_pkg::WAY_W'(w);
				have_empty = 1'b1;
			end
		end
		found = |match;

		ptr_next = (rd_row.ptr == sacl_pkg::WAY_W'(sacl_pkg::WAYS - 1)) ? '0
			: rd_row.ptr + 1'b1;

		if (found) begin
			chosen = hit_way;
		end else if (have_empty) begin
			chosen = empty_way;
		end else begin
			chosen = rd_row.ptr;
		end

		wr_row              = rd_row;
		wr_row.valid[chosen] = 1'b1;
		wr_row.tag[chosen]   = tag_s1;
		if (!have_empty) begin
			wr_row.ptr = ptr_next;
		end
	end

	// next state and RAM control
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		commit    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = set_s1;
		ram_wdata = ROW_W'(wr_row);
		unique case (state_q)
			sacl_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == sacl_pkg::SET_BITS'(sacl_pkg::SETS - 1)) begin
					state_d = sacl_pkg::ST_IDLE;
				end
			end
			sacl_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = sacl_pkg::ST_LOOKUP;
				end
			end
			sacl_pkg::ST_LOOKUP: begin
				// hold the read row until the output register is free
				if (!out_valid_q || rsp.ready) begin
					commit  = 1'b1;
					ram_we  = !found;
					state_d = sacl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sacl_pkg::ST_CLEAR;
			end
		endcase
		ram_re = req.valid && req.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacl_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			req_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sacl_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				req_cnt_q   <= req_cnt_q + 1'b1;
				if (!found) begin
					miss_cnt_q <= miss_cnt_q + 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			set_s1 <= req.addr[sacl_pkg::SET_BITS-1:0];
			tag_s1 <= req.addr[sacl_pkg::ADDR_USE-1:sacl_pkg::SET_BITS];
		end
		if (commit) begin
			out_hit_q <= found;
			out_way_q <= sacl_pkg::OUT_WAY_W'(chosen);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = out_hit_q;
	assign rsp.way           = out_way_q;
	assign rsp.request_count = req_cnt_q;
	assign rsp.miss_count    = miss_cnt_q;

`ifndef NO_ASSERTIONS
	a_req_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> req_cnt_q == $past(req_cnt_q) + 1'b1)
		else $error("request counter did not advance by one");

	a_miss_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (miss_cnt_q - $past(miss_cnt_q)) == (out_hit_q ? 32'd0 : 32'd1))
		else $error("miss counter disagrees with delivered hit flag");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sacl_pkg::ST_CLEAR |-> !ram_re)
		else $error("request accepted during clearing pass");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sacl_pkg::ST_CLEAR && state_d != sacl_pkg::ST_CLEAR)
		|-> clr_q == sacl_pkg::SET_BITS'(sacl_pkg::SETS - 1))
		else $error("clearing pass ended before the last row");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q && $stable(out_way_q))
		else $error("pending result dropped or changed");
`endif

endmodule

FILE: tb/tb_set_assoc_cache_tag_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_lookup_core: self-checking bench for the tag lookup
// Drives lookup requests through the valid/ready channel and predicts hit,
// way and both counters with a private copy of the tag, valid and victim
// pointer state. Directed fills, hits and pointer wraps come first, then
// random traffic aimed at a few hot sets, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_lookup_core;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_PERCENT  = 27;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STUCK_LIMIT   = 5000;
	localparam int SET_POOL      = 8;
	localparam int TAG_POOL      = 6;
	localparam int HOT_PERCENT   = 85;

	typedef struct packed {
		logic                           hit;
		logic [sacl_pkg::OUT_WAY_W-1:0] way;
		logic [sacl_pkg::CNT_W-1:0]     request_count;
		logic [sacl_pkg::CNT_W-1:0]     miss_count;
	} lookup_result_t;

	class lookup_scoreboard;
		bit                         valid_bits [sacl_pkg::SETS*sacl_pkg::WAYS];
		logic [sacl_pkg::TAG_W-1:0] tag_store [sacl_pkg::SETS*sacl_pkg::WAYS];
		int unsigned                next_victim [sacl_pkg::SETS];
		logic [sacl_pkg::CNT_W-1:0] request_total;
		logic [sacl_pkg::CNT_W-1:0] miss_total;
		lookup_result_t             expected_q [$];
		int                         errors;
		int                         hit_total;
		int                         fill_total;
		int                         replace_total;

		function new();
			foreach (valid_bits[i]) valid_bits[i] = 1'b0;
			foreach (next_victim[i]) next_victim[i] = 0;
			request_total = '0;
			miss_total    = '0;
			errors        = 0;
			hit_total     = 0;
			fill_total    = 0;
			replace_total = 0;
		endfunction

		function void note_request(logic [sacl_pkg::IN_ADDR_W-1:0] addr);
			logic [sacl_pkg::ADDR_USE-1:0] a;
			logic [sacl_pkg::TAG_W-1:0]    tag;
			int unsigned                   set_idx;
			int unsigned                   base;
			int unsigned                   chosen;
			int unsigned                   empty_way;
			bit                            found;
			bit                            have_empty;
			lookup_result_t                r;
			a          = addr[sacl_pkg::ADDR_USE-1:0];
			set_idx    = a[sacl_pkg::SET_BITS-1:0];
			tag        = a[sacl_pkg::ADDR_USE-1:sacl_pkg::SET_BITS];
			base       = set_idx * sacl_pkg::WAYS;
			found      = 1'b0;
			have_empty = 1'b0;
			chosen     = 0;
			empty_way  = 0;
			request_total++;
			for (int w = 0; w < sacl_pkg::WAYS; w++) begin
				if (valid_bits[base+w]) begin
					if (!found && tag_store[base+w] == tag) begin
						found  = 1'b1;
						chosen = w;
					end
				end else if (!have_empty) begin
					have_empty = 1'b1;
					empty_way  = w;
				end
			end
			if (found) begin
				hit_total++;
			end else begin
				miss_total++;
				if (have_empty) begin
					chosen = empty_way;
					fill_total++;
				end else begin
					// replace the round-robin victim, then advance with wrap
					chosen = next_victim[set_idx] % sacl_pkg::WAYS;
					next_victim[set_idx] = (chosen + 1) % sacl_pkg::WAYS;
					replace_total++;
				end
				valid_bits[base+chosen] = 1'b1;
				tag_store[base+chosen]  = tag;
			end
			r.hit           = found;
			r.way           = sacl_pkg::OUT_WAY_W'(chosen);
			r.request_count = request_total;
			r.miss_count    = miss_total;
			expected_q.push_back(r);
		endfunction

		function void check_result(lookup_result_t got);
			lookup_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request outstanding: hit %0d way %0d",
					got.hit, got.way);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got.hit);
				errors++;
			end
			if (got.way !== want.way) begin
				$error("way: expected %0d, actual %0d", want.way, got.way);
				errors++;
			end
			if (got.request_count !== want.request_count) begin
				$error("request_count: expected %0d, actual %0d",
					want.request_count, got.request_count);
				errors++;
			end
			if (got.miss_count !== want.miss_count) begin
				$error("miss_count: expected %0d, actual %0d",
					want.miss_count, got.miss_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sacl_lookup_if req_ch ();
	sacl_result_if rsp_ch ();

	set_assoc_cache_tag_lookup_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	lookup_scoreboard                sb;
	bit                              no_idle;
	bit                              hold_off_go;
	int                              hold_offs_done;
	logic [sacl_pkg::SET_BITS-1:0]   hot_sets [SET_POOL];
	logic [sacl_pkg::TAG_W-1:0]      tag_pool [TAG_POOL];

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic logic [sacl_pkg::IN_ADDR_W-1:0] make_addr(
		logic [sacl_pkg::TAG_W-1:0] tag, logic [sacl_pkg::SET_BITS-1:0] set_idx);
		return {tag, set_idx};
	endfunction

	// mostly hot sets with a small tag pool, so hits and replacements mix
	function automatic logic [sacl_pkg::IN_ADDR_W-1:0] pick_addr();
		if ($urandom_range(99) < HOT_PERCENT)
			return make_addr(tag_pool[$urandom_range(TAG_POOL-1)],
				hot_sets[$urandom_range(SET_POOL-1)]);
		return $urandom;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_lookup(input logic [sacl_pkg::IN_ADDR_W-1:0] a);
		while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.addr  <= a;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(a);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_lookup(pick_addr());
	endtask

	task automatic wait_drained();
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	// result side: random ready, plus a long hold-off on request
	initial begin
		int hold_left;
		lookup_result_t got;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_go) begin
				hold_off_go = 1'b0;
				hold_left   = HOLD_CYCLES;
				hold_offs_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.hit           = rsp_ch.hit;
				got.way           = rsp_ch.way;
				got.request_count = rsp_ch.request_count;
				got.miss_count    = rsp_ch.miss_count;
				sb.check_result(got);
			end
		end
	end

	// end the run if nothing moves for too long
	initial begin
		int stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("timeout: no request or result moved for %0d cycles", stuck);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		sb             = new();
		no_idle        = 1'b0;
		hold_off_go    = 1'b0;
		hold_offs_done = 0;
		arst_n         = 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.addr   <= '0;

		hot_sets[0] = '0;
		hot_sets[1] = '1;
		for (int i = 2; i < SET_POOL; i++)
			hot_sets[i] = sacl_pkg::SET_BITS'($urandom_range(sacl_pkg::SETS-1));
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < TAG_POOL; i++)
			tag_pool[i] = sacl_pkg::TAG_W'($urandom);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// extremes of the address, with a repeat hit on the first two
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_lookup(32'hFFFF_FFFF);
		send_lookup(make_addr('1, '0));
		send_lookup(make_addr('0, '1));
		// fill the remaining empty ways of set 0, pointer holds
		send_lookup(make_addr(sacl_pkg::TAG_W'(1), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(2), '0));
		// set 0 full: replace through the pointer and wrap it
		send_lookup(make_addr(sacl_pkg::TAG_W'(3), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(4), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(3), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(5), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(6), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(7), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(0), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(8), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(7), '0));
		send_lookup(make_addr(sacl_pkg::TAG_W'(1), '0));
		send_lookup(32'hAAAA_AAAA);
		send_lookup(32'h5555_5555);
		send_lookup(32'hAAAA_AAAA);
		send_lookup(32'h5555_5555);

		send_random(400);

		// pause the sender until every result is back
		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		// hold off the result side while requests keep coming
		hold_off_go = 1'b1;
		send_random(40);

		no_idle = 1'b1;
		send_random(400);
		no_idle = 1'b0;

		send_random(440);

		req_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.expected_q.size() != 0) begin
			$error("%0d results never arrived", sb.expected_q.size());
			sb.errors++;
		end
		$display("covered %0d lookups: %0d hits, %0d fills of empty ways, %0d replacements",
			sb.request_total, sb.hit_total, sb.fill_total, sb.replace_total);
		$display("random gaps on both sides, %0d long result hold-off(s), one drain pause",
			hold_offs_done);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
